[rtl/triangle_tangent_bitangent_core_macros.svh]
// Assertion macros for the triangle tangent/bitangent core.
// Included by the top level; no other dependencies.
`ifndef TRIANGLE_TANGENT_BITANGENT_CORE_MACROS_SVH
`define TRIANGLE_TANGENT_BITANGENT_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define TTB_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ttb assertion failed");
`define TTB_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ttb assertion failed");
`else
`define TTB_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define TTB_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

[rtl/ttb_pkg.sv]
// Shared widths, types and the output packing function of the tangent core.
// No dependencies.
`timescale 1ns / 1ps
package ttb_pkg;
    localparam int COMP_WIDTH  = 16;
    localparam int OUT_FRAC    = COMP_WIDTH - 2;
    localparam int POS_W       = 16;
    localparam int EDGE_W      = POS_W + 1;
    localparam int PROD_W      = 2 * EDGE_W;
    localparam int DET_W       = PROD_W + 1;
    localparam int VEC_W       = PROD_W + 2;
    localparam int MAG_W       = VEC_W;
    localparam int LEAD_W      = $clog2(MAG_W);
    localparam int NORM_TOP    = 29;
    localparam int NORM_W      = NORM_TOP + 1;
    localparam int SQ_W        = 2 * NORM_W;
    localparam int SUM_W       = SQ_W + 2;
    localparam int SQRT_W      = 64;
    localparam int SQRT_STEPS  = 32;
    localparam int ROOT_W      = NORM_W + 1;
    localparam int QUO_W       = COMP_WIDTH;
    localparam int NUM_W       = NORM_W + OUT_FRAC + 1;
    localparam int REM_W       = ROOT_W + QUO_W;
    localparam int LANE_LAT    = 5 + SQRT_STEPS + 1 + QUO_W + 1;
    localparam int FRONT_LAT   = 4;
    localparam int PIPE_LAT    = FRONT_LAT + LANE_LAT + 1;
    localparam int EPS_W       = 16;
    localparam int FIELD_W     = 48;

    typedef logic [VEC_W-1:0] t_vcomp;
    typedef t_vcomp [2:0] t_vec;
    typedef logic [COMP_WIDTH-1:0] t_comp;
    typedef t_comp [2:0] t_comp3;

    typedef struct packed {
        t_comp3 comp;
        logic   zero;
    } t_lane_out;

    // Components sit at a stride of COMP_WIDTH from bit 0; whatever lies
    // beyond the 48-bit field is dropped.
    function automatic logic [FIELD_W-1:0] pack3(input t_comp3 c);
        logic [3*COMP_WIDTH+FIELD_W-1:0] w;
        w = {{FIELD_W{1'b0}}, c[2], c[1], c[0]};
        return w[FIELD_W-1:0];
    endfunction
endpackage

[rtl/ttb_in_if.sv]
// Triangle input channel: valid/ready plus positions and texture coordinates.
// No dependencies.
`timescale 1ns / 1ps
interface ttb_in_if;
    logic        valid;
    logic        ready;
    logic [47:0] pos_a;
    logic [47:0] pos_b;
    logic [47:0] pos_c;
    logic [31:0] uv_a;
    logic [31:0] uv_b;
    logic [31:0] uv_c;
    modport source (output valid, pos_a, pos_b, pos_c, uv_a, uv_b, uv_c, input ready);
    modport sink (input valid, pos_a, pos_b, pos_c, uv_a, uv_b, uv_c, output ready);
endinterface

[rtl/ttb_out_if.sv]
// Result channel: valid/ready plus unit tangent, bitangent and flags.
// No dependencies.
`timescale 1ns / 1ps
interface ttb_out_if;
    logic        valid;
    logic        ready;
    logic [47:0] tangent_out;
    logic [47:0] bitangent_out;
    logic        uv_degenerate;
    logic        zero_vector;
    modport source (output valid, tangent_out, bitangent_out, uv_degenerate, zero_vector,
                    input ready);
    modport sink (input valid, tangent_out, bitangent_out, uv_degenerate, zero_vector,
                  output ready);
endinterface

[rtl/ttb_cfg_if.sv]
// Configuration write channel: valid/ready plus the epsilon write data.
// No dependencies.
`timescale 1ns / 1ps
interface ttb_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] data;
    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

[rtl/ttb_norm_lane.sv]
// Pipelined vector normalizer: block scaling, square sum, square root, divide.
// Depends on ttb_pkg.
`timescale 1ns / 1ps
module ttb_norm_lane (
    input  logic              i_clk,
    input  logic              i_adv,
    input  ttb_pkg::t_vec     i_vec,
    output ttb_pkg::t_lane_out o_res
);
    import ttb_pkg::*;

    // Stage 1: magnitudes, signs and the largest magnitude.
    logic [MAG_W-1:0]  r_mag1 [3];
    logic [2:0]        r_sgn1;
    logic [MAG_W-1:0]  r_max1;
    logic [MAG_W-1:0]  n_mag1 [3];
    logic [MAG_W-1:0]  n_max1;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_mag1[i] = i_vec[i][VEC_W-1] ? (~i_vec[i] + 1'b1) : i_vec[i];
        end
        n_max1 = n_mag1[0];
        if (n_mag1[1] > n_max1) n_max1 = n_mag1[1];
        if (n_mag1[2] > n_max1) n_max1 = n_mag1[2];
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            for (int i = 0; i < 3; i++) r_mag1[i] <= n_mag1[i];
            r_sgn1[0] <= i_vec[0][VEC_W-1];
            r_sgn1[1] <= i_vec[1][VEC_W-1];
            r_sgn1[2] <= i_vec[2][VEC_W-1];
            r_max1    <= n_max1;
        end
    end

    // Stage 2: position of the leading one of the largest magnitude.
    logic [MAG_W-1:0]  r_mag2 [3];
    logic [2:0]        r_sgn2;
    logic [LEAD_W-1:0] r_lead2;
    logic              r_zero2;
    logic [LEAD_W-1:0] n_lead2;

    always_comb begin
        n_lead2 = '0;
        for (int i = 0; i < MAG_W; i++) begin
            if (r_max1[i]) n_lead2 = LEAD_W'(i);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            for (int i = 0; i < 3; i++) r_mag2[i] <= r_mag1[i];
            r_sgn2  <= r_sgn1;
            r_lead2 <= n_lead2;
            r_zero2 <= (r_max1 == '0);
        end
    end

    // Stage 3: shift all magnitudes together so the largest is in [2^29, 2^30).
    logic [NORM_W-1:0] r_nm3 [3];
    logic [2:0]        r_sgn3;
    logic              r_zero3;
    logic [MAG_W-1:0]  n_sh3 [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (r_lead2 >= LEAD_W'(NORM_TOP)) begin
                n_sh3[i] = r_mag2[i] >> (r_lead2 - LEAD_W'(NORM_TOP));
            end else begin
                n_sh3[i] = r_mag2[i] << (LEAD_W'(NORM_TOP) - r_lead2);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            for (int i = 0; i < 3; i++) r_nm3[i] <= n_sh3[i][NORM_W-1:0];
            r_sgn3  <= r_sgn2;
            r_zero3 <= r_zero2;
        end
    end

    // Stage 4: squares.
    logic [SQ_W-1:0]   r_sq4 [3];
    logic [NORM_W-1:0] r_nm4 [3];
    logic [2:0]        r_sgn4;
    logic              r_zero4;

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            for (int i = 0; i < 3; i++) begin
                r_sq4[i] <= r_nm3[i] * r_nm3[i];
                r_nm4[i] <= r_nm3[i];
            end
            r_sgn4  <= r_sgn3;
            r_zero4 <= r_zero3;
        end
    end

    // Stage 5 and the square root chain: one result bit per stage.
    logic [SQRT_W-1:0] r_rn  [0:SQRT_STEPS];
    logic [SQRT_W-1:0] r_res [0:SQRT_STEPS];
    logic [NORM_W-1:0] r_snm [0:SQRT_STEPS][3];
    logic [2:0]        r_ssg [0:SQRT_STEPS];
    logic              r_szr [0:SQRT_STEPS];

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_rn[0]  <= SQRT_W'(r_sq4[0]) + SQRT_W'(r_sq4[1]) + SQRT_W'(r_sq4[2]);
            r_res[0] <= '0;
            for (int i = 0; i < 3; i++) r_snm[0][i] <= r_nm4[i];
            r_ssg[0] <= r_sgn4;
            r_szr[0] <= r_zero4;
        end
    end

    for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
        localparam logic [SQRT_W-1:0] Bit = SQRT_W'(1) << (SQRT_W - 2 - 2 * j);
        logic [SQRT_W-1:0] n_trial;
        assign n_trial = r_res[j] + Bit;

        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                if (r_rn[j] >= n_trial) begin
                    r_rn[j+1]  <= r_rn[j] - n_trial;
                    r_res[j+1] <= (r_res[j] >> 1) + Bit;
                end else begin
                    r_rn[j+1]  <= r_rn[j];
                    r_res[j+1] <= r_res[j] >> 1;
                end
                for (int i = 0; i < 3; i++) r_snm[j+1][i] <= r_snm[j][i];
                r_ssg[j+1] <= r_ssg[j];
                r_szr[j+1] <= r_szr[j];
            end
        end
    end

    // Divider chain: restoring division, one quotient bit per stage.
    logic [REM_W-1:0]  r_rem [0:QUO_W][3];
    logic [QUO_W-1:0]  r_quo [0:QUO_W][3];
    logic [ROOT_W-1:0] r_div [0:QUO_W];
    logic [2:0]        r_dsg [0:QUO_W];
    logic              r_dzr [0:QUO_W];
    logic [ROOT_W-1:0] n_root;

    assign n_root = r_res[SQRT_STEPS][ROOT_W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            for (int i = 0; i < 3; i++) begin
                r_rem[0][i] <= REM_W'({r_snm[SQRT_STEPS][i], {OUT_FRAC{1'b0}}})
                             + REM_W'(n_root >> 1);
                r_quo[0][i] <= '0;
            end
            r_div[0] <= n_root;
            r_dsg[0] <= r_ssg[SQRT_STEPS];
            r_dzr[0] <= r_szr[SQRT_STEPS];
        end
    end

    for (genvar j = 0; j < QUO_W; j++) begin : g_div
        localparam int Pos = QUO_W - 1 - j;
        logic [REM_W-1:0] n_sub;
        assign n_sub = REM_W'(r_div[j]) << Pos;

        always_ff @(posedge i_clk) begin
            if (i_adv) begin
                for (int i = 0; i < 3; i++) begin
                    if (r_rem[j][i] >= n_sub) begin
                        r_rem[j+1][i] <= r_rem[j][i] - n_sub;
                        r_quo[j+1][i] <= r_quo[j][i] | (QUO_W'(1) << Pos);
                    end else begin
                        r_rem[j+1][i] <= r_rem[j][i];
                        r_quo[j+1][i] <= r_quo[j][i];
                    end
                end
                r_div[j+1] <= r_div[j];
                r_dsg[j+1] <= r_dsg[j];
                r_dzr[j+1] <= r_dzr[j];
            end
        end
    end

    // Final stage: restore signs, force zero for a zero vector.
    t_lane_out r_out;

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            for (int i = 0; i < 3; i++) begin
                if (r_dzr[QUO_W]) begin
                    r_out.comp[i] <= '0;
                end else if (r_dsg[QUO_W][i]) begin
                    r_out.comp[i] <= ~r_quo[QUO_W][i] + 1'b1;
                end else begin
                    r_out.comp[i] <= r_quo[QUO_W][i];
                end
            end
            r_out.zero <= r_dzr[QUO_W];
        end
    end

    assign o_res = r_out;
endmodule

[rtl/triangle_tangent_bitangent_core.sv]
// Triangle tangent/bitangent core, top level: edge and UV-delta front end,
// two normalizer lanes, output register. Depends on ttb_pkg, the channel
// interfaces, ttb_norm_lane and the assertion macro header.
//
// One triangle per beat goes in, one result beat comes out, in order. The
// pipeline is 60 register stages deep (four front-end stages, 55 stages in
// each normalizer lane, one output register), and one triangle can be taken
// every cycle unless a result is held in the output register.
// The depth is set by the normalizer: a 32-stage square-root chain and a
// 16-stage divider chain, one bit step per stage. The whole pipeline moves
// as one; when a result waits in the output register and the sink is not
// ready, every stage holds and input ready drops, so nothing is lost or
// repeated. The epsilon register resets to 1 and is meant to be written only
// while the pipeline is empty; its write channel is always ready.
`timescale 1ns / 1ps
`include "triangle_tangent_bitangent_core_macros.svh"
module triangle_tangent_bitangent_core (
    input  logic i_clk,
    input  logic i_rst_n,
    ttb_in_if.sink    i_tri,
    ttb_cfg_if.sink   i_cfg,
    ttb_out_if.source o_res
);
    import ttb_pkg::*;

    // Configuration register.
    logic [EPS_W-1:0] r_uv_epsilon;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_uv_epsilon <= EPS_W'(1);
        end else if (i_cfg.valid) begin
            r_uv_epsilon <= i_cfg.data;
        end
    end

    // The pipeline advances unless the output register holds a result that
    // the sink does not take.
    logic                r_vld [PIPE_LAT];
    logic                n_adv;

    assign n_adv       = !r_vld[PIPE_LAT-1] || o_res.ready;
    assign i_tri.ready = n_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < PIPE_LAT; k++) r_vld[k] <= 1'b0;
        end else if (n_adv) begin
            r_vld[0] <= i_tri.valid;
            for (int k = 1; k < PIPE_LAT; k++) r_vld[k] <= r_vld[k-1];
        end
    end

    // Stage 1: position edges and UV deltas, all 17-bit signed.
    logic signed [EDGE_W-1:0] r_e1 [3];
    logic signed [EDGE_W-1:0] r_e2 [3];
    logic signed [EDGE_W-1:0] r_d1u, r_d1v, r_d2u, r_d2v;

    function automatic logic signed [EDGE_W-1:0] sub16(input logic [15:0] x,
                                                       input logic [15:0] y);
        return $signed({x[15], x}) - $signed({y[15], y});
    endfunction

    always_ff @(posedge i_clk) begin
        if (n_adv) begin
            for (int i = 0; i < 3; i++) begin
                r_e1[i] <= sub16(i_tri.pos_b[16*i +: 16], i_tri.pos_a[16*i +: 16]);
                r_e2[i] <= sub16(i_tri.pos_c[16*i +: 16], i_tri.pos_a[16*i +: 16]);
            end
            r_d1u <= sub16(i_tri.uv_b[15:0], i_tri.uv_a[15:0]);
            r_d1v <= sub16(i_tri.uv_b[31:16], i_tri.uv_a[31:16]);
            r_d2u <= sub16(i_tri.uv_c[15:0], i_tri.uv_a[15:0]);
            r_d2v <= sub16(i_tri.uv_c[31:16], i_tri.uv_a[31:16]);
        end
    end

    // Stage 2: all partial products of the determinant, T and B.
    logic signed [PROD_W-1:0] r_pd1, r_pd2;
    logic signed [PROD_W-1:0] r_pt1 [3];
    logic signed [PROD_W-1:0] r_pt2 [3];
    logic signed [PROD_W-1:0] r_pb1 [3];
    logic signed [PROD_W-1:0] r_pb2 [3];

    always_ff @(posedge i_clk) begin
        if (n_adv) begin
            r_pd1 <= r_d1u * r_d2v;
            r_pd2 <= r_d1v * r_d2u;
            for (int i = 0; i < 3; i++) begin
                r_pt1[i] <= r_e1[i] * r_d2v;
                r_pt2[i] <= r_e2[i] * r_d1v;
                r_pb1[i] <= r_e2[i] * r_d1u;
                r_pb2[i] <= r_e1[i] * r_d2u;
            end
        end
    end

    // Stage 3: differences.
    logic signed [DET_W-1:0] r_det;
    logic signed [DET_W-1:0] r_t3 [3];
    logic signed [DET_W-1:0] r_b3 [3];

    always_ff @(posedge i_clk) begin
        if (n_adv) begin
            r_det <= DET_W'(r_pd1) - DET_W'(r_pd2);
            for (int i = 0; i < 3; i++) begin
                r_t3[i] <= DET_W'(r_pt1[i]) - DET_W'(r_pt2[i]);
                r_b3[i] <= DET_W'(r_pb1[i]) - DET_W'(r_pb2[i]);
            end
        end
    end

    // Stage 4: degenerate test against epsilon and sign of the determinant.
    // A determinant within epsilon of zero counts as positive. The flag is
    // indexed by pipeline stage, so the entry at PIPE_LAT sits beside the
    // output register.
    logic [DET_W-1:0] n_adet;
    logic             n_degen;
    logic             n_neg;
    t_vec             r_t4, r_b4;
    logic             r_deg [FRONT_LAT:PIPE_LAT];

    assign n_adet  = r_det[DET_W-1] ? DET_W'(-r_det) : DET_W'(r_det);
    assign n_degen = n_adet <= DET_W'(r_uv_epsilon);
    assign n_neg   = !n_degen && r_det[DET_W-1];

    always_ff @(posedge i_clk) begin
        if (n_adv) begin
            for (int i = 0; i < 3; i++) begin
                if (n_neg) begin
                    r_t4[i] <= VEC_W'(-VEC_W'(r_t3[i]));
                    r_b4[i] <= VEC_W'(-VEC_W'(r_b3[i]));
                end else begin
                    r_t4[i] <= VEC_W'(r_t3[i]);
                    r_b4[i] <= VEC_W'(r_b3[i]);
                end
            end
            r_deg[FRONT_LAT] <= n_degen;
            for (int k = FRONT_LAT + 1; k <= PIPE_LAT; k++) r_deg[k] <= r_deg[k-1];
        end
    end

    // Normalizer lanes, one per vector.
    t_lane_out n_tan, n_bit;

    ttb_norm_lane u_lane_t (
        .i_clk (i_clk),
        .i_adv (n_adv),
        .i_vec (r_t4),
        .o_res (n_tan)
    );

    ttb_norm_lane u_lane_b (
        .i_clk (i_clk),
        .i_adv (n_adv),
        .i_vec (r_b4),
        .o_res (n_bit)
    );

    // Output register.
    logic [FIELD_W-1:0] r_tan_out, r_bit_out;
    logic               r_zero_out;

    always_ff @(posedge i_clk) begin
        if (n_adv) begin
            r_tan_out  <= pack3(n_tan.comp);
            r_bit_out  <= pack3(n_bit.comp);
            r_zero_out <= n_tan.zero || n_bit.zero;
        end
    end

    assign o_res.valid         = r_vld[PIPE_LAT-1];
    assign o_res.tangent_out   = r_tan_out;
    assign o_res.bitangent_out = r_bit_out;
    assign o_res.uv_degenerate = r_deg[PIPE_LAT];
    assign o_res.zero_vector   = r_zero_out;

    // A held result must stop the input side.
    `TTB_ASSERT_IMP(a_stall_blocks_input, i_clk, i_rst_n, r_vld[PIPE_LAT-1] && !o_res.ready, !i_tri.ready)
    // An accepted triangle occupies the first stage on the next edge.
    `TTB_ASSERT_NXT(a_accept_enters, i_clk, i_rst_n, i_tri.valid && i_tri.ready, r_vld[0])
    // A zero-vector flag comes with an all-zero tangent or bitangent.
    `TTB_ASSERT_IMP(a_zero_flag_data, i_clk, i_rst_n, o_res.valid && o_res.zero_vector, o_res.tangent_out == '0 || o_res.bitangent_out == '0)
endmodule
